// File: rtl/core/rnfh_pkg.sv
// Shared types and constants of the ring node frame handler.
package rnfh_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int CRC_BITS    = 8;

  localparam logic [7:0] CRC_POLY = 8'h9B;

  // Command numbers carried in frame byte 5
  localparam logic [7:0] CMD_LED   = 8'd100;
  localparam logic [7:0] CMD_COUNT = 8'd101;
  localparam logic [7:0] CMD_UID_AB = 8'd102;
  localparam logic [7:0] CMD_UID_C  = 8'd103;

  // Control from the frame sequencer to the serial CRC unit
  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctl_t;

  // Control from the frame sequencer to the press counter
  typedef struct packed {
    logic press;
    logic clear;
  } press_ctl_t;

endpackage

// File: rtl/core/ring_node_frame_handler.sv
// Ring node frame handler: 16-byte frame receiver, command unit and frame sender.
//
// Usage:
//   s_* carries requests: s_tuser[0] = 1 marks a button press whose tick is in
//   s_tdata[39:8]; s_tuser[0] = 0 carries a received frame byte in s_tdata[7:0].
//   Frames are counted from reset, 16 bytes each. m_* carries sent frame bytes,
//   m_tlast on the sixteenth; m_tuser holds the LED state and the bad command flag.
//   cfg_* writes registers: 0 node address, 1 version, 2 debounce, 3..5 UID words.
// Timing:
//   A press or a frame byte at positions 0, 14 is simply accepted; bytes 1..13 are
//   each accepted and then run through the bit-serial CRC, one bit per cycle.
//   The last byte starts the check and edit, then the new CRC is run over
//   13 bytes before the first output byte is sent.
//   Output bytes then leave at one per cycle while the receiver does not stall.
//   The single CRC shift unit serves both the received and the sent frame.
// Reset clears position, CRC, press count, LED and registers to their defaults.
// A stalled receiver holds m_*; s_tready stays low until the last byte of the
// frame is in the output register.
module ring_node_frame_handler import rnfh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] press_time_ms
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] tx_byte
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [0] led_on, [1] bad_command
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] CFG_NODE  = 3'd0;
  localparam logic [2:0] CFG_VER   = 3'd1;
  localparam logic [2:0] CFG_DEB   = 3'd2;
  localparam logic [2:0] CFG_UID_A = 3'd3;
  localparam logic [2:0] CFG_UID_B = 3'd4;
  localparam logic [2:0] CFG_UID_C = 3'd5;

  localparam logic [3:0] POS_LAST  = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] POS_CRC   = 4'(FRAME_BYTES - 2);
  localparam logic [3:0] POS_DLAST = 4'(FRAME_BYTES - 3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC_RX,
    ST_CHECK,
    ST_EDIT,
    ST_CRC_LOAD,
    ST_CRC_WAIT,
    ST_SEND
  } state_t;

  state_t      state;
  logic [3:0]  pos;
  logic [3:0]  idx;
  logic [7:0]  store [FRAME_BYTES];
  logic        led_state;
  logic        bad_cmd;

  logic [7:0]  node_address;
  logic [7:0]  protocol_version;
  logic [15:0] debounce_ms;
  logic [31:0] uid_word_a;
  logic [31:0] uid_word_b;
  logic [31:0] uid_word_c;

  logic        in_fire;
  logic        rx_fire;
  logic        frame_ok;
  logic        forward;
  logic        slot_free;
  logic [7:0]  tx_byte_next;
  logic [7:0]  crc;
  logic        crc_busy;
  logic [7:0]  crc_data;
  logic [7:0]  press_count;
  crc_ctl_t    crc_ctl;
  press_ctl_t  press_ctl;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign rx_fire   = in_fire && !s_tuser[0];
  assign slot_free = !m_tvalid || m_tready;

  assign frame_ok = (store[14] == crc) && (store[1] != 8'd0) && (store[2] == 8'd0) &&
                    (store[3] == protocol_version);
  assign forward  = (store[1] != node_address);

  assign crc_ctl.clear = (rx_fire && pos == 4'd0) || (state == ST_EDIT);
  assign crc_ctl.start = (rx_fire && pos != 4'd0 && pos <= POS_DLAST) ||
                         (state == ST_CRC_LOAD);
  assign crc_data      = rx_fire ? s_tdata[7:0] : store[idx];

  assign press_ctl.press = in_fire && s_tuser[0];
  assign press_ctl.clear = (state == ST_EDIT) && !forward && (store[5] == CMD_COUNT);

  always_comb begin
    if (idx == 4'd0 || idx == POS_LAST) begin
      tx_byte_next = 8'd0;
    end else if (idx == POS_CRC) begin
      tx_byte_next = crc;
    end else begin
      tx_byte_next = store[idx];
    end
  end

  rnfh_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (crc_data),
    .busy (crc_busy),
    .crc  (crc)
  );

  rnfh_press u_press (
    .clk         (clk),
    .rst         (rst),
    .ctl         (press_ctl),
    .press_time  (s_tdata[39:8]),
    .debounce_ms (debounce_ms),
    .count       (press_count)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address     <= 8'd3;
      protocol_version <= 8'd5;
      debounce_ms      <= 16'd10;
      uid_word_a       <= 32'd0;
      uid_word_b       <= 32'd0;
      uid_word_c       <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NODE:  node_address     <= cfg_data[7:0];
        CFG_VER:   protocol_version <= cfg_data[7:0];
        CFG_DEB:   debounce_ms      <= cfg_data[15:0];
        CFG_UID_A: uid_word_a       <= cfg_data;
        CFG_UID_B: uid_word_b       <= cfg_data;
        CFG_UID_C: uid_word_c       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame store: received bytes, rewritten in place into the outgoing frame
  always_ff @(posedge clk) begin
    if (rx_fire) begin
      store[pos] <= s_tdata[7:0];
    end else if (state == ST_EDIT) begin
      if (forward) begin
        store[4] <= store[4] + 8'd1;
      end else begin
        store[1] <= 8'd0;
        store[2] <= node_address;
        store[3] <= protocol_version;
        store[4] <= 8'd0;
        case (store[5])
          CMD_COUNT: store[13] <= press_count;
          CMD_UID_AB: begin
            store[6]  <= uid_word_a[7:0];
            store[7]  <= uid_word_a[15:8];
            store[8]  <= uid_word_a[23:16];
            store[9]  <= uid_word_a[31:24];
            store[10] <= uid_word_b[7:0];
            store[11] <= uid_word_b[15:8];
            store[12] <= uid_word_b[23:16];
            store[13] <= uid_word_b[31:24];
          end
          CMD_UID_C: begin
            store[6] <= uid_word_c[7:0];
            store[7] <= uid_word_c[15:8];
            store[8] <= uid_word_c[23:16];
            store[9] <= uid_word_c[31:24];
          end
          default: ;
        endcase
      end
    end
  end

  // Frame sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= 4'd0;
      idx       <= 4'd0;
      led_state <= 1'b0;
      bad_cmd   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // Drop the sent byte; the send state reloads the register itself
      if (m_tvalid && m_tready && state != ST_SEND) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rx_fire) begin
            pos <= pos + 4'd1;
            if (pos != 4'd0 && pos <= POS_DLAST) begin
              state <= ST_CRC_RX;
            end else if (pos == POS_LAST) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CRC_RX: begin
          if (!crc_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_CHECK: begin
          state <= frame_ok ? ST_EDIT : ST_IDLE;
        end
        ST_EDIT: begin
          bad_cmd <= 1'b0;
          if (!forward) begin
            case (store[5]) inside
              CMD_LED: led_state <= (store[13] != 8'd0);
              CMD_COUNT, CMD_UID_AB, CMD_UID_C: ;
              default: bad_cmd <= 1'b1;
            endcase
          end
          idx   <= 4'd1;
          state <= ST_CRC_LOAD;
        end
        ST_CRC_LOAD: begin
          state <= ST_CRC_WAIT;
        end
        ST_CRC_WAIT: begin
          if (!crc_busy) begin
            if (idx == POS_DLAST) begin
              idx   <= 4'd0;
              state <= ST_SEND;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_CRC_LOAD;
            end
          end
        end
        ST_SEND: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= tx_byte_next;
            m_tlast  <= (idx == POS_LAST);
            m_tuser  <= {bad_cmd, led_state};
            idx      <= idx + 4'd1;
            if (idx == POS_LAST) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_crc_busy_in_crc_state: assert property (@(posedge clk) disable iff (rst)
    crc_busy |-> (state == ST_CRC_RX || state == ST_CRC_WAIT))
    else $error("CRC unit busy outside a CRC state");

  a_pos_holds: assert property (@(posedge clk) disable iff (rst)
    !rx_fire |=> $stable(pos))
    else $error("frame position moved without a received byte");

  a_out_from_send: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_SEND)
    else $error("output became valid outside the send state");
`endif

endmodule

// File: rtl/core/rnfh_crc.sv
// Bit-serial CRC-8 unit, one message bit per cycle, MSB first.
module rnfh_crc import rnfh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  crc_ctl_t   ctl,
  input  logic [7:0] data,
  output logic       busy,
  output logic [7:0] crc
);

  logic [7:0] shreg;
  logic [3:0] cnt;
  logic       fb;

  assign busy = (cnt != 4'd0);
  assign fb   = crc[7] ^ shreg[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
      crc <= 8'd0;
    end else if (ctl.clear) begin
      cnt <= 4'd0;
      crc <= 8'd0;
    end else if (ctl.start) begin
      cnt <= 4'(CRC_BITS);
    end else if (busy) begin
      crc <= {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'd0);
      cnt <= cnt - 4'd1;
    end
  end

  // Message byte shifts out MSB first
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shreg <= data;
    end else if (busy) begin
      shreg <= {shreg[6:0], 1'b0};
    end
  end

endmodule

// File: rtl/core/rnfh_press.sv
// Debounced button press counter.
module rnfh_press import rnfh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  press_ctl_t  ctl,
  input  logic [31:0] press_time,
  input  logic [15:0] debounce_ms,
  output logic [7:0]  count
);

  logic [31:0] last_time;
  logic [31:0] elapsed;
  logic        counts;

  assign elapsed = press_time - last_time;
  assign counts  = elapsed > {16'd0, debounce_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 8'd0;
      last_time <= 32'd0;
    end else if (ctl.clear) begin
      count <= 8'd0;
    end else if (ctl.press && counts) begin
      count     <= count + 8'd1;
      last_time <= press_time;
    end
  end

endmodule
